/* sv/sec_pkg.sv */
// ----------------------------------------------------------------------------
// sec_pkg: shared constants and helpers for the SHA-256 entropy conditioner
// Round constants, initial hash values, batch geometry and the round helpers.
// ----------------------------------------------------------------------------
`default_nettype none
package sec_pkg;

  localparam int RawWords    = 10;
  localparam int DigestWords = 8;
  localparam int QueueDepth  = 16;
  localparam int CntW        = 4;
  localparam int RoundW      = 6;
  localparam int QPtrW       = 4;

  // Message length in bits, placed in the last schedule word.
  localparam logic [31:0] MsgBits = 32'(RawWords * 32);
  localparam logic [31:0] PadWord = 32'h8000_0000;

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Queue entry from the front end: a word and a batch-complete mark.
  typedef struct packed {
    logic [31:0] word;
    logic        batch_end;
  } q_entry_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] swap_bytes(input logic [31:0] x);
    swap_bytes = {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage
`default_nettype wire

/* sv/sha256_entropy_conditioner_top.sv */
// ----------------------------------------------------------------------------
// sha256_entropy_conditioner_top: SHA-256 entropy conditioner
// Ten raw words in, eight byte-swapped digest words out, last word flagged.
// ----------------------------------------------------------------------------
// Raw words are taken one per cycle, unless in_stall is raised, into a 16-entry
// queue; the hash engine drains a batch of ten, pads it, runs 64 rounds and
// sends out eight words, last digest word first, one per cycle when the
// output is not stalled. The queue absorbs the next batch while the engine
// works.
`default_nettype none
module sha256_entropy_conditioner_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_raw_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_entropy_word,
  output logic             out_last_of_run
);

  logic              push, full, pop, empty;
  sec_pkg::q_entry_t push_data, head;

  sec_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_raw_word,
    .push, .push_data, .q_full(full)
  );

  sec_queue u_queue (
    .clk, .rst_n, .push, .push_data, .full, .pop, .empty, .head
  );

  sec_engine u_engine (
    .clk, .rst_n, .q_empty(empty), .q_head(head), .q_pop(pop),
    .out_valid, .out_stall, .out_entropy_word, .out_last_of_run
  );

endmodule
`default_nettype wire

/* sv/sec_front.sv */
// ----------------------------------------------------------------------------
// sec_front: input stage
// Accepts raw words, counts the batch and marks the word that completes it.
// ----------------------------------------------------------------------------
`default_nettype none
module sec_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [31:0]        in_raw_word,
  output logic                    push,
  output sec_pkg::q_entry_t       push_data,
  input  wire logic               q_full
);

  logic [sec_pkg::CntW-1:0] cnt_r, cnt_nxt;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // Batch completes on the RawWords-th word.
  always_comb begin
    push_data.word      = in_raw_word;
    push_data.batch_end = (cnt_r >= sec_pkg::CntW'(sec_pkg::RawWords - 1));
    cnt_nxt = cnt_r;
    if (push) begin
      cnt_nxt = push_data.batch_end ? '0 : cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

/* sv/sec_queue.sv */
// ----------------------------------------------------------------------------
// sec_queue: decoupling FIFO
// Holds words and their batch-end marks between the front end and the hash engine.
// ----------------------------------------------------------------------------
`default_nettype none
module sec_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire sec_pkg::q_entry_t  push_data,
  output logic                    full,
  input  wire logic               pop,
  output logic                    empty,
  output sec_pkg::q_entry_t       head
);

  sec_pkg::q_entry_t mem [sec_pkg::QueueDepth];
  logic [sec_pkg::QPtrW-1:0] wp_r, rp_r;
  logic [sec_pkg::QPtrW:0]   n_r;

  assign full  = (n_r == (sec_pkg::QPtrW+1)'(sec_pkg::QueueDepth));
  assign empty = (n_r == '0);
  assign head  = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= push_data;
    end
  end

  // Pointer and occupancy update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      n_r  <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      n_r <= n_r + (sec_pkg::QPtrW+1)'(push) - (sec_pkg::QPtrW+1)'(pop);
    end
  end

endmodule
`default_nettype wire

/* sv/sec_engine.sv */
// ----------------------------------------------------------------------------
// sec_engine: hash back end
// Loads the schedule window from the queue, pads it, runs 64 rounds, emits 8 words.
// ----------------------------------------------------------------------------
`default_nettype none
module sec_engine (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_empty,
  input  wire sec_pkg::q_entry_t  q_head,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [31:0]             out_entropy_word,
  output logic                    out_last_of_run
);

  localparam logic [1:0] StLoad = 2'd0;
  localparam logic [1:0] StPad  = 2'd1;
  localparam logic [1:0] StRun  = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  logic [1:0]  st_r;
  logic [3:0]  wi_r;      // schedule load index
  logic [5:0]  rnd_r;     // round counter
  logic [2:0]  eidx_r;    // digest index being emitted
  logic        ofull_r;
  logic [31:0] w_r [16];  // schedule window
  logic [31:0] v_r [8];   // working variables
  logic [31:0] ow_r;
  logic        ol_r;

  logic [31:0] w_cur, w15, w2, g0, g1, t1, t2, s0, s1, ch, maj;
  logic [31:0] dg;
  logic        can_out;

  assign q_pop = (st_r == StLoad) && !q_empty;
  assign out_valid        = ofull_r;
  assign out_entropy_word = ow_r;
  assign out_last_of_run  = ol_r;
  assign can_out = !ofull_r || !out_stall;

  // One SHA-256 round.
  always_comb begin
    w15 = w_r[4'(rnd_r - 6'd15)];
    w2  = w_r[4'(rnd_r - 6'd2)];
    g0  = sec_pkg::rotr(w15, 7) ^ sec_pkg::rotr(w15, 18) ^ (w15 >> 3);
    g1  = sec_pkg::rotr(w2, 17) ^ sec_pkg::rotr(w2, 19) ^ (w2 >> 10);
    if (rnd_r < 6'd16) begin
      w_cur = w_r[rnd_r[3:0]];
    end else begin
      w_cur = w_r[rnd_r[3:0]] + g0 + w_r[4'(rnd_r - 6'd7)] + g1;
    end
    s1  = sec_pkg::rotr(v_r[4], 6) ^ sec_pkg::rotr(v_r[4], 11) ^ sec_pkg::rotr(v_r[4], 25);
    ch  = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1  = v_r[7] + s1 + ch + sec_pkg::RoundK[rnd_r] + w_cur;
    s0  = sec_pkg::rotr(v_r[0], 2) ^ sec_pkg::rotr(v_r[0], 13) ^ sec_pkg::rotr(v_r[0], 22);
    maj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2  = s0 + maj;
    dg  = sec_pkg::InitH[eidx_r] + v_r[eidx_r];
  end

  // Datapath: schedule, variables and output register.
  always_ff @(posedge clk) begin
    case (st_r)
      StLoad: begin
        if (q_pop) begin
          w_r[wi_r] <= q_head.word;
        end
      end
      StPad: begin
        w_r[wi_r] <= (wi_r == 4'd15) ? sec_pkg::MsgBits :
                     (wi_r == 4'(sec_pkg::RawWords)) ? sec_pkg::PadWord : '0;
        if (wi_r == 4'd15) begin
          for (int i = 0; i < 8; i++) v_r[i] <= sec_pkg::InitH[i];
        end
      end
      StRun: begin
        w_r[rnd_r[3:0]] <= w_cur;
        v_r[7] <= v_r[6];
        v_r[6] <= v_r[5];
        v_r[5] <= v_r[4];
        v_r[4] <= v_r[3] + t1;
        v_r[3] <= v_r[2];
        v_r[2] <= v_r[1];
        v_r[1] <= v_r[0];
        v_r[0] <= t1 + t2;
      end
      StEmit: begin
        if (can_out) begin
          ow_r <= sec_pkg::swap_bytes(dg);
          ol_r <= (eidx_r == 3'd0);
        end
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= StLoad;
      wi_r    <= '0;
      rnd_r   <= '0;
      eidx_r  <= 3'd7;
      ofull_r <= 1'b0;
    end else begin
      // Output register holds until taken, reloads on each emit
      ofull_r <= (ofull_r && out_stall) || ((st_r == StEmit) && can_out);
      case (st_r)
        StLoad: begin
          if (q_pop) begin
            wi_r <= wi_r + 1'b1;
            if (q_head.batch_end) st_r <= StPad;
          end
        end
        StPad: begin
          wi_r <= wi_r + 1'b1;
          if (wi_r == 4'd15) begin
            st_r  <= StRun;
            rnd_r <= '0;
          end
        end
        StRun: begin
          rnd_r <= rnd_r + 1'b1;
          if (rnd_r == 6'd63) begin
            st_r   <= StEmit;
            eidx_r <= 3'd7;
          end
        end
        StEmit: begin
          if (can_out) begin
            eidx_r  <= eidx_r - 1'b1;
            if (eidx_r == 3'd0) begin
              st_r <= StLoad;
              wi_r <= '0;
            end
          end
        end
        default: st_r <= StLoad;
      endcase
    end
  end

endmodule
`default_nettype wire
